FILE: rtl/core/cpe_pkg.sv
// ----------------------------------------------------------------------------
// Cart-pole Euler step package
// Shared types, constants, saturation helper and the step microprogram.
// ----------------------------------------------------------------------------
package cpe_pkg;

  localparam int unsigned RF_AW = 4;
  localparam int unsigned PC_W  = 7;
  localparam int unsigned CNT_W = 6;

  localparam logic [CNT_W-1:0] MUL_LAST = 6'd31;
  localparam logic [CNT_W-1:0] DIV_LAST = 6'd63;
  localparam logic [PC_W-1:0]  PC_LAST  = 7'd67;

  localparam logic [63:0] DMAX64 = 64'h0000_0000_7fff_ffff;
  localparam logic [63:0] DMIN64 = 64'hffff_ffff_8000_0000;

  // config register indexes
  localparam logic [1:0] CF_GRAV  = 2'd0;
  localparam logic [1:0] CF_FORCE = 2'd1;
  localparam logic [1:0] CF_TRACK = 2'd2;
  localparam logic [1:0] CF_ANGLE = 2'd3;

  // state register indexes
  localparam logic [1:0] ST_X  = 2'd0;
  localparam logic [1:0] ST_V  = 2'd1;
  localparam logic [1:0] ST_TH = 2'd2;
  localparam logic [1:0] ST_W  = 2'd3;

  // scratch file addresses
  localparam logic [RF_AW-1:0] R_TH  = 4'd0;
  localparam logic [RF_AW-1:0] R_T   = 4'd1;
  localparam logic [RF_AW-1:0] R_U   = 4'd2;
  localparam logic [RF_AW-1:0] R_A2  = 4'd3;
  localparam logic [RF_AW-1:0] R_P   = 4'd4;
  localparam logic [RF_AW-1:0] R_S30 = 4'd5;
  localparam logic [RF_AW-1:0] R_C30 = 4'd6;
  localparam logic [RF_AW-1:0] R_SN  = 4'd7;
  localparam logic [RF_AW-1:0] R_CS  = 4'd8;
  localparam logic [RF_AW-1:0] R_NV  = 4'd9;
  localparam logic [RF_AW-1:0] R_NX  = 4'd10;
  localparam logic [RF_AW-1:0] R_NT  = 4'd11;
  localparam logic [RF_AW-1:0] R_NW  = 4'd12;
  localparam logic [RF_AW-1:0] R_W   = 4'd13;

  // immediates
  localparam logic [31:0] K_HALF_H = 32'd51472;   // half of pi/2 in Q16
  localparam logic [31:0] K_H      = 32'd102944;  // pi/2 in Q16
  localparam logic [31:0] K_ONE30  = 32'd1073741824;
  localparam logic [31:0] K_43     = 32'd87381;   // 4/3 in Q16
  localparam logic [31:0] K_NONE   = 32'd0;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EXEC, S_WAIT, S_DONE
  } fsm_e;

  typedef enum logic [4:0] {
    OP_LDS, OP_LDC, OP_FRC, OP_ADD, OP_RSUB, OP_ADDS, OP_SUBS, OP_SHL14,
    OP_X10, OP_QS, OP_QC, OP_STS, OP_MULQ, OP_MUL30, OP_DIV, OP_DIVQ, OP_RED
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [RF_AW-1:0] dst;
    logic [RF_AW-1:0] sa;
    logic [RF_AW-1:0] sb;
    logic             bk;
    logic [31:0]      imm;
  } uc_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } su_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } su_stat_t;

  function automatic logic [63:0] sat32(input logic [63:0] v);
    if ($signed(v) > $signed(DMAX64)) return DMAX64;
    if ($signed(v) < $signed(DMIN64)) return DMIN64;
    return v;
  endfunction

  function automatic logic is_serial(input op_e op);
    return (op inside {OP_MULQ, OP_MUL30, OP_DIV, OP_DIVQ, OP_RED});
  endfunction

  function automatic uc_t mk(input op_e op, input logic [RF_AW-1:0] dst,
                             input logic [RF_AW-1:0] sa, input logic [RF_AW-1:0] sb,
                             input logic bk, input logic [31:0] imm);
    uc_t u;
    u.op  = op;
    u.dst = dst;
    u.sa  = sa;
    u.sb  = sb;
    u.bk  = bk;
    u.imm = imm;
    return u;
  endfunction

  function automatic uc_t ucode(input logic [PC_W-1:0] pc);
    case (pc)
      // range reduction and Taylor series in Q2.30
      7'd0:  return mk(OP_LDS,   R_TH,  R_TH,  R_TH,  1'b0, {30'd0, ST_TH});
      7'd1:  return mk(OP_ADD,   R_T,   R_TH,  R_TH,  1'b1, K_HALF_H);
      7'd2:  return mk(OP_RED,   R_U,   R_T,   R_TH,  1'b1, K_H);
      7'd3:  return mk(OP_SHL14, R_U,   R_U,   R_TH,  1'b0, K_NONE);
      7'd4:  return mk(OP_MUL30, R_A2,  R_U,   R_U,   1'b0, K_NONE);
      7'd5:  return mk(OP_DIV,   R_P,   R_A2,  R_TH,  1'b1, 32'd72);
      7'd6:  return mk(OP_RSUB,  R_P,   R_P,   R_TH,  1'b1, K_ONE30);
      7'd7:  return mk(OP_MUL30, R_P,   R_A2,  R_P,   1'b0, K_NONE);
      7'd8:  return mk(OP_DIV,   R_P,   R_P,   R_TH,  1'b1, 32'd42);
      7'd9:  return mk(OP_RSUB,  R_P,   R_P,   R_TH,  1'b1, K_ONE30);
      7'd10: return mk(OP_MUL30, R_P,   R_A2,  R_P,   1'b0, K_NONE);
      7'd11: return mk(OP_DIV,   R_P,   R_P,   R_TH,  1'b1, 32'd20);
      7'd12: return mk(OP_RSUB,  R_P,   R_P,   R_TH,  1'b1, K_ONE30);
      7'd13: return mk(OP_MUL30, R_P,   R_A2,  R_P,   1'b0, K_NONE);
      7'd14: return mk(OP_DIV,   R_P,   R_P,   R_TH,  1'b1, 32'd6);
      7'd15: return mk(OP_RSUB,  R_P,   R_P,   R_TH,  1'b1, K_ONE30);
      7'd16: return mk(OP_MUL30, R_S30, R_U,   R_P,   1'b0, K_NONE);
      7'd17: return mk(OP_DIV,   R_P,   R_A2,  R_TH,  1'b1, 32'd90);
      7'd18: return mk(OP_RSUB,  R_P,   R_P,   R_TH,  1'b1, K_ONE30);
      7'd19: return mk(OP_MUL30, R_P,   R_A2,  R_P,   1'b0, K_NONE);
      7'd20: return mk(OP_DIV,   R_P,   R_P,   R_TH,  1'b1, 32'd56);
      7'd21: return mk(OP_RSUB,  R_P,   R_P,   R_TH,  1'b1, K_ONE30);
      7'd22: return mk(OP_MUL30, R_P,   R_A2,  R_P,   1'b0, K_NONE);
      7'd23: return mk(OP_DIV,   R_P,   R_P,   R_TH,  1'b1, 32'd30);
      7'd24: return mk(OP_RSUB,  R_P,   R_P,   R_TH,  1'b1, K_ONE30);
      7'd25: return mk(OP_MUL30, R_P,   R_A2,  R_P,   1'b0, K_NONE);
      7'd26: return mk(OP_DIV,   R_P,   R_P,   R_TH,  1'b1, 32'd12);
      7'd27: return mk(OP_RSUB,  R_P,   R_P,   R_TH,  1'b1, K_ONE30);
      7'd28: return mk(OP_MUL30, R_P,   R_A2,  R_P,   1'b0, K_NONE);
      7'd29: return mk(OP_DIV,   R_P,   R_P,   R_TH,  1'b1, 32'd2);
      7'd30: return mk(OP_RSUB,  R_C30, R_P,   R_TH,  1'b1, K_ONE30);
      7'd31: return mk(OP_QS,    R_SN,  R_S30, R_C30, 1'b0, K_NONE);
      7'd32: return mk(OP_QC,    R_CS,  R_S30, R_C30, 1'b0, K_NONE);
      // dynamics
      7'd33: return mk(OP_LDS,   R_W,   R_TH,  R_TH,  1'b0, {30'd0, ST_W});
      7'd34: return mk(OP_MULQ,  R_T,   R_W,   R_W,   1'b0, K_NONE);
      7'd35: return mk(OP_MULQ,  R_T,   R_T,   R_SN,  1'b0, K_NONE);
      7'd36: return mk(OP_DIV,   R_T,   R_T,   R_TH,  1'b1, 32'd20);
      7'd37: return mk(OP_FRC,   R_U,   R_TH,  R_TH,  1'b0, K_NONE);
      7'd38: return mk(OP_ADDS,  R_T,   R_U,   R_T,   1'b0, K_NONE);
      7'd39: return mk(OP_X10,   R_T,   R_T,   R_TH,  1'b0, K_NONE);
      7'd40: return mk(OP_DIV,   R_T,   R_T,   R_TH,  1'b1, 32'd11);
      7'd41: return mk(OP_LDC,   R_U,   R_TH,  R_TH,  1'b0, {30'd0, CF_GRAV});
      7'd42: return mk(OP_MULQ,  R_U,   R_U,   R_SN,  1'b0, K_NONE);
      7'd43: return mk(OP_MULQ,  R_A2,  R_CS,  R_T,   1'b0, K_NONE);
      7'd44: return mk(OP_SUBS,  R_U,   R_U,   R_A2,  1'b0, K_NONE);
      7'd45: return mk(OP_MULQ,  R_A2,  R_CS,  R_CS,  1'b0, K_NONE);
      7'd46: return mk(OP_DIV,   R_A2,  R_A2,  R_TH,  1'b1, 32'd11);
      7'd47: return mk(OP_RSUB,  R_A2,  R_A2,  R_TH,  1'b1, K_43);
      7'd48: return mk(OP_DIV,   R_A2,  R_A2,  R_TH,  1'b1, 32'd2);
      7'd49: return mk(OP_DIVQ,  R_U,   R_U,   R_A2,  1'b0, K_NONE);
      7'd50: return mk(OP_MULQ,  R_A2,  R_U,   R_CS,  1'b0, K_NONE);
      7'd51: return mk(OP_DIV,   R_A2,  R_A2,  R_TH,  1'b1, 32'd22);
      7'd52: return mk(OP_SUBS,  R_T,   R_T,   R_A2,  1'b0, K_NONE);
      7'd53: return mk(OP_DIV,   R_T,   R_T,   R_TH,  1'b1, 32'd50);
      7'd54: return mk(OP_LDS,   R_P,   R_TH,  R_TH,  1'b0, {30'd0, ST_V});
      7'd55: return mk(OP_ADDS,  R_NV,  R_P,   R_T,   1'b0, K_NONE);
      7'd56: return mk(OP_DIV,   R_T,   R_P,   R_TH,  1'b1, 32'd50);
      7'd57: return mk(OP_LDS,   R_P,   R_TH,  R_TH,  1'b0, {30'd0, ST_X});
      7'd58: return mk(OP_ADDS,  R_NX,  R_P,   R_T,   1'b0, K_NONE);
      7'd59: return mk(OP_DIV,   R_T,   R_W,   R_TH,  1'b1, 32'd50);
      7'd60: return mk(OP_LDS,   R_P,   R_TH,  R_TH,  1'b0, {30'd0, ST_TH});
      7'd61: return mk(OP_ADDS,  R_NT,  R_P,   R_T,   1'b0, K_NONE);
      7'd62: return mk(OP_DIV,   R_T,   R_U,   R_TH,  1'b1, 32'd50);
      7'd63: return mk(OP_ADDS,  R_NW,  R_W,   R_T,   1'b0, K_NONE);
      // commit
      7'd64: return mk(OP_STS,   R_TH,  R_NX,  R_TH,  1'b0, {30'd0, ST_X});
      7'd65: return mk(OP_STS,   R_TH,  R_NV,  R_TH,  1'b0, {30'd0, ST_V});
      7'd66: return mk(OP_STS,   R_TH,  R_NT,  R_TH,  1'b0, {30'd0, ST_TH});
      7'd67: return mk(OP_STS,   R_TH,  R_NW,  R_TH,  1'b0, {30'd0, ST_W});
      default: return mk(OP_STS, R_TH,  R_NW,  R_TH,  1'b0, {30'd0, ST_W});
    endcase
  endfunction

endpackage

FILE: rtl/core/cpe_serial_unit.sv
// ----------------------------------------------------------------------------
// Cart-pole bit-serial arithmetic unit
// Shift-add multiplier (32 steps) and restoring divider (64 steps), one bit
// per cycle, on unsigned magnitudes.
// ----------------------------------------------------------------------------
module cpe_serial_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpe_pkg::su_ctrl_t ctrl_i,
  input  logic [63:0]       opa_i,
  input  logic [31:0]       opb_i,
  output cpe_pkg::su_stat_t stat_o,
  output logic [63:0]       res_o,
  output logic [31:0]       rem_o
);
  import cpe_pkg::*;

  logic             busy_q, done_q, is_div_q;
  logic [CNT_W-1:0] cnt_q;
  logic [63:0]      acc_q, acc_d;
  logic [31:0]      rem_q, rem_d, b_q;
  logic [32:0]      sum, trial;
  logic             ge;

  always_comb begin
    sum   = {1'b0, acc_q[63:32]} + (acc_q[0] ? {1'b0, b_q} : 33'd0);
    trial = {rem_q, acc_q[63]};
    ge    = (trial >= {1'b0, b_q});
    if (is_div_q) begin
      acc_d = {acc_q[62:0], ge};
      rem_d = ge ? 32'(trial - {1'b0, b_q}) : trial[31:0];
    end else begin
      acc_d = {sum, acc_q[31:1]};
      rem_d = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctrl_i.is_div ? DIV_LAST : MUL_LAST;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q    <= ctrl_i.is_div ? opa_i : {32'd0, opa_i[31:0]};
      rem_q    <= '0;
      b_q      <= opb_i;
      is_div_q <= ctrl_i.is_div;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = acc_q;
  assign rem_o       = rem_q;

endmodule

FILE: rtl/core/cart_pole_euler_step_unit.sv
// ----------------------------------------------------------------------------
// Cart-pole Euler step unit
// Keeps the cart and pole state in Q16.16 and advances it one 0.02 s step
// per transaction through a microcoded sequencer and a bit-serial unit.
// ----------------------------------------------------------------------------
// Usage: send one transaction on the input channel (valid/ready); req_type 1
// zeroes the state, req_type 0 advances one step pushing right or left. Each
// transaction gives exactly one result transaction carrying the new state and
// the failed flag. Configuration is a plain write port (gravity, force, track
// limit, angle limit) and must be written only while the unit is idle.
// Sequence: a step runs 68 microinstructions, each fetched and then
// executed; each of the 15 serial multiplies and 20 serial divides also waits
// for the bit-serial unit, and the result is then loaded into the output
// register. A state reset item goes straight to loading the result. One item
// is in work at a time. The result sits in an output register, so a stalled
// receiver does not block finishing the next step; a step that finishes while
// the previous result still waits holds until that result is taken.
// Reset clears the state to zero and loads the default configuration.
// ----------------------------------------------------------------------------
module cart_pole_euler_step_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [21:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_req_type_i,
  input  logic               in_push_right_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_cart_position_o,
  output logic signed [31:0] out_cart_velocity_o,
  output logic signed [31:0] out_pole_angle_o,
  output logic signed [31:0] out_pole_angular_velocity_o,
  output logic               out_failed_o
);
  import cpe_pkg::*;

  fsm_e             state_q, state_d;
  logic [PC_W-1:0]  pc_q;
  uc_t              instr;
  logic [63:0]      rf [2**RF_AW];
  logic [63:0]      rd_a_q, rd_b_q;
  logic [1:0]       quad_q;
  logic             push_q;
  logic [21:0]      grav_q, force_q, tlim_q;
  logic [17:0]      alim_q;
  logic [31:0]      pos_q, vel_q, ang_q, angv_q;
  logic             out_valid_q;

  logic             in_fire, serial, instr_done, rf_we, st_we, out_load;
  su_ctrl_t         su_ctrl;
  su_stat_t         su_stat;
  logic [63:0]      su_opa, su_res;
  logic [31:0]      su_opb, su_rem;
  logic [63:0]      a_op, b_op, a_mag, b_mag, wr_data, so, co, up30;
  logic [47:0]      sh16;
  logic             neg_ab;
  logic [1:0]       quad_d;
  logic signed [32:0] ang_e, pos_e, lim_a, lim_t;
  logic             failed;

  assign instr   = ucode(pc_q);
  assign serial  = is_serial(instr.op);
  assign in_fire = in_valid_i && in_ready_o;

  assign a_op   = rd_a_q;
  assign b_op   = instr.bk ? {32'd0, instr.imm} : rd_b_q;
  assign a_mag  = a_op[63] ? 64'(-a_op) : a_op;
  assign b_mag  = b_op[63] ? 64'(-b_op) : b_op;
  assign neg_ab = a_op[63] ^ b_op[63];

  // serial unit control and operands
  always_comb begin
    su_ctrl.start  = (state_q == S_EXEC) && serial;
    su_ctrl.is_div = (instr.op == OP_DIV) || (instr.op == OP_DIVQ) || (instr.op == OP_RED);
    su_opa = a_mag;
    su_opb = b_op[31:0];
    case (instr.op)
      OP_MULQ, OP_MUL30: begin
        su_opb = b_mag[31:0];
      end
      OP_DIVQ: begin
        su_opa = {a_mag[47:0], 16'd0};
        su_opb = ($signed(b_op) <= 0) ? 32'd1 : b_op[31:0];
      end
      default: begin
        su_opa = a_mag;
      end
    endcase
  end

  cpe_serial_unit u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (su_ctrl),
    .opa_i  (su_opa),
    .opb_i  (su_opb),
    .stat_o (su_stat),
    .res_o  (su_res),
    .rem_o  (su_rem)
  );

  // result of the current microinstruction
  always_comb begin
    wr_data = '0;
    quad_d  = quad_q;
    so      = a_op;
    co      = b_op;
    sh16    = su_res[63:16];
    up30    = {30'd0, su_res[63:30]} + {63'd0, |su_res[29:0]};
    case (quad_q)
      2'd0: begin so = a_op;         co = b_op;         end
      2'd1: begin so = b_op;         co = 64'(-a_op);   end
      2'd2: begin so = 64'(-a_op);   co = 64'(-b_op);   end
      default: begin so = 64'(-b_op); co = a_op;        end
    endcase
    case (instr.op)
      OP_LDS: begin
        case (instr.imm[1:0])
          ST_X:    wr_data = {{32{pos_q[31]}}, pos_q};
          ST_V:    wr_data = {{32{vel_q[31]}}, vel_q};
          ST_TH:   wr_data = {{32{ang_q[31]}}, ang_q};
          default: wr_data = {{32{angv_q[31]}}, angv_q};
        endcase
      end
      OP_LDC:   wr_data = {42'd0, grav_q};
      OP_FRC:   wr_data = push_q ? {42'd0, force_q} : 64'(-{42'd0, force_q});
      OP_ADD:   wr_data = a_op + b_op;
      OP_RSUB:  wr_data = b_op - a_op;
      OP_ADDS:  wr_data = sat32(a_op + b_op);
      OP_SUBS:  wr_data = sat32(a_op - b_op);
      OP_SHL14: wr_data = {a_op[49:0], 14'd0};
      OP_X10:   wr_data = {a_op[60:0], 3'd0} + {a_op[62:0], 1'd0};
      OP_QS:    wr_data = 64'($signed(so + 64'd8192) >>> 14);
      OP_QC:    wr_data = 64'($signed(co + 64'd8192) >>> 14);
      OP_MULQ: begin
        if (sh16 > 48'h7fff_ffff) begin
          wr_data = neg_ab ? DMIN64 : DMAX64;
        end else begin
          wr_data = neg_ab ? 64'(-{16'd0, sh16}) : {16'd0, sh16};
        end
      end
      OP_MUL30: wr_data = neg_ab ? 64'(-up30) : {30'd0, su_res[63:30]};
      OP_DIV:   wr_data = a_op[63] ? 64'(-su_res) : su_res;
      OP_DIVQ: begin
        if (su_res > DMAX64) begin
          wr_data = a_op[63] ? DMIN64 : DMAX64;
        end else begin
          wr_data = a_op[63] ? 64'(-su_res) : su_res;
        end
      end
      OP_RED: begin
        // floor-mod by pi/2, then center the remainder
        if (!a_op[63]) begin
          quad_d  = su_res[1:0];
          wr_data = {32'd0, su_rem} - {32'd0, K_HALF_H};
        end else if (su_rem != '0) begin
          quad_d  = ~su_res[1:0];
          wr_data = b_op - {32'd0, su_rem} - {32'd0, K_HALF_H};
        end else begin
          quad_d  = 2'(~su_res[1:0] + 2'd1);
          wr_data = 64'(-{32'd0, K_HALF_H});
        end
      end
      default: wr_data = a_op;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = in_req_type_i ? S_DONE : S_FETCH;
      end
      S_FETCH: state_d = S_EXEC;
      S_EXEC: begin
        if (serial) state_d = S_WAIT;
        else if (pc_q == PC_LAST) state_d = S_DONE;
        else state_d = S_FETCH;
      end
      S_WAIT: begin
        if (su_stat.done) state_d = (pc_q == PC_LAST) ? S_DONE : S_FETCH;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    instr_done    = ((state_q == S_EXEC) && !serial) || ((state_q == S_WAIT) && su_stat.done);
    rf_we         = instr_done && (instr.op != OP_STS);
    st_we         = instr_done && (instr.op == OP_STS);
    out_load      = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire) pc_q <= '0;
      else if (instr_done) pc_q <= pc_q + 1'b1;
    end
  end

  // scratch file: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (rf_we) rf[instr.dst] <= wr_data;
    if (state_q == S_FETCH) begin
      rd_a_q <= rf[instr.sa];
      rd_b_q <= rf[instr.sb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) push_q <= in_push_right_i;
    if (instr_done && (instr.op == OP_RED)) quad_q <= quad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q  <= 22'd642253;
      force_q <= 22'd655360;
      tlim_q  <= 22'd157286;
      alim_q  <= 18'd13726;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CF_GRAV:  grav_q  <= cfg_wdata_i;
        CF_FORCE: force_q <= cfg_wdata_i;
        CF_TRACK: tlim_q  <= cfg_wdata_i;
        CF_ANGLE: alim_q  <= cfg_wdata_i[17:0];
        default:  grav_q  <= grav_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      vel_q  <= '0;
      ang_q  <= '0;
      angv_q <= '0;
    end else if (in_fire && in_req_type_i) begin
      pos_q  <= '0;
      vel_q  <= '0;
      ang_q  <= '0;
      angv_q <= '0;
    end else if (st_we) begin
      case (instr.imm[1:0])
        ST_X:    pos_q  <= a_op[31:0];
        ST_V:    vel_q  <= a_op[31:0];
        ST_TH:   ang_q  <= a_op[31:0];
        default: angv_q <= a_op[31:0];
      endcase
    end
  end

  assign ang_e  = {ang_q[31], ang_q};
  assign pos_e  = {pos_q[31], pos_q};
  assign lim_a  = {15'd0, alim_q};
  assign lim_t  = {11'd0, tlim_q};
  assign failed = (ang_e < -lim_a) || (ang_e > lim_a) || (pos_e < -lim_t) || (pos_e > lim_t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cart_position_o         <= pos_q;
      out_cart_velocity_o         <= vel_q;
      out_pole_angle_o            <= ang_q;
      out_pole_angular_velocity_o <= angv_q;
      out_failed_o                <= failed;
    end
  end

  assign out_valid_o = out_valid_q;

  a_busy_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    su_stat.busy |-> (state_q == S_WAIT))
    else $error("serial unit busy outside wait state");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input taken while a step is in work");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC || state_q == S_WAIT) |-> (pc_q <= PC_LAST))
    else $error("microprogram counter out of range");

  a_load_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (state_q == S_IDLE))
    else $error("result load did not free the sequencer");

endmodule
